// ===== rtl/mmbr_pkg.sv =====
// Package for the matrix multiply with bias and ReLU block.
// Holds request, token and cell control types, function and register codes, and the output saturation with ReLU.
// No dependencies.
`default_nettype none

package mmbr_pkg;

  localparam int OPERAND_W = 16;
  localparam int PROD_W    = 2 * OPERAND_W;
  localparam int ACC_W     = 48;
  localparam int RES_W     = 32;
  localparam int BIAS_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_STREAM = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_USED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_BIAS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELU_ENABLE = 3'd4;

  typedef struct packed {
    logic [1:0]                  func;
    logic [3:0]                  row_index;
    logic [5:0]                  depth_index;
    logic signed [OPERAND_W-1:0] operand;
    logic signed [BIAS_W-1:0]    bias_value;
  } in_req_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic [3:0]              result_row;
    logic [15:0]             result_col;
    logic                    last_of_column;
    logic                    last_of_matrix;
  } out_req_t;

  typedef struct packed {
    logic                        vld;
    logic [1:0]                  func;
    logic [3:0]                  row;
    logic [5:0]                  dep;
    logic signed [OPERAND_W-1:0] opnd;
    logic signed [BIAS_W-1:0]    bias;
    logic                        first;
    logic                        last;
  } tok_t;

  typedef struct packed {
    logic add_bias;
    logic relu_enable;
    logic shift;
  } cell_ctrl_t;

  function automatic logic signed [RES_W-1:0] sat_relu(input logic [ACC_W-1:0] acc,
                                                       input logic relu);
    logic [ACC_W-RES_W:0]    top;
    logic signed [RES_W-1:0] v;
    top = acc[ACC_W-1:RES_W-1];
    if ((top == '0) || (top == '1)) begin
      v = acc[RES_W-1:0];
    end else if (acc[ACC_W-1]) begin
      v = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      v = {1'b0, {(RES_W-1){1'b1}}};
    end
    if (relu && v[RES_W-1]) begin
      v = '0;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mmbr_cell.sv =====
// One multiply-accumulate cell of the row chain: weights and bias of one row, its accumulator.
// Passes requests to the next cell each cycle and shifts results toward row zero.
// Depends on mmbr_pkg.
`default_nettype none

module mmbr_cell import mmbr_pkg::*; #(
  parameter int CELL_IDX  = 0,
  parameter int MAX_DEPTH = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tok_t                    tok_in,
  output tok_t                         tok_out,
  input  wire logic                    row_en,
  input  wire cell_ctrl_t              ctrl,
  input  wire logic signed [RES_W-1:0] res_in,
  output logic signed [RES_W-1:0]      res_out,
  output logic                         cap
);

  localparam int DAW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [6:0] IDX = 7'(CELL_IDX);

  logic [OPERAND_W-1:0]        wmem_r [MAX_DEPTH];
  logic signed [OPERAND_W-1:0] rdata_r;
  logic signed [BIAS_W-1:0]    bias_r;

  logic [DAW-1:0] addr;
  logic           row_hit;
  logic           is_w;
  logic           is_b;
  logic           is_s;

  tok_t                     tok_r;
  logic                     s1_act_r;
  logic signed [BIAS_W-1:0] s1_init_r;

  logic signed [PROD_W-1:0] prod_r;
  logic                     s2_act_r;
  logic                     s2_first_r;
  logic                     s2_last_r;
  logic signed [BIAS_W-1:0] s2_init_r;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic             fin_r;

  logic signed [RES_W-1:0] res_r;
  logic                    cap_r;

  assign addr    = DAW'(tok_in.dep);
  assign row_hit = ({3'b000, tok_in.row} == IDX);
  assign is_w    = tok_in.vld && (tok_in.func == FUNC_WEIGHT) && row_hit;
  assign is_b    = tok_in.vld && (tok_in.func == FUNC_BIAS) && row_hit;
  assign is_s    = tok_in.vld && (tok_in.func == FUNC_STREAM) && row_en;

  always_ff @(posedge clk) begin
    if (is_w) begin
      wmem_r[addr] <= tok_in.opnd;
    end
    if (is_s) begin
      rdata_r <= wmem_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (is_b) begin
      bias_r <= tok_in.bias;
    end
    tok_r.func  <= tok_in.func;
    tok_r.row   <= tok_in.row;
    tok_r.dep   <= tok_in.dep;
    tok_r.opnd  <= tok_in.opnd;
    tok_r.bias  <= tok_in.bias;
    tok_r.first <= tok_in.first;
    tok_r.last  <= tok_in.last;
    s1_init_r   <= ctrl.add_bias ? bias_r : '0;
    prod_r      <= rdata_r * tok_r.opnd;
    s2_first_r  <= tok_r.first;
    s2_last_r   <= tok_r.last;
    s2_init_r   <= s1_init_r;
    if (fin_r) begin
      res_r <= sat_relu(acc_r, ctrl.relu_enable);
    end else if (ctrl.shift) begin
      res_r <= res_in;
    end
  end

  always_comb begin
    acc_nxt = (s2_first_r ? {{(ACC_W-BIAS_W){s2_init_r[BIAS_W-1]}}, s2_init_r} : acc_r)
            + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      s1_act_r  <= 1'b0;
      s2_act_r  <= 1'b0;
      fin_r     <= 1'b0;
      cap_r     <= 1'b0;
      acc_r     <= '0;
    end else begin
      tok_r.vld <= tok_in.vld;
      s1_act_r  <= is_s;
      s2_act_r  <= s1_act_r;
      fin_r     <= s2_act_r && s2_last_r;
      cap_r     <= fin_r;
      if (s2_act_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  assign tok_out = tok_r;
  assign res_out = res_r;
  assign cap     = cap_r;

endmodule

`default_nettype wire

// ===== rtl/matrix_multiply_bias_relu.sv =====
// Weight-stationary matrix multiply with optional bias and ReLU, built from a chain of row cells.
// Load requests and stream requests other than a column's last element are taken one per cycle.
// After a column's last element the input stalls until its results drain; the first result leaves
// once the cell chain's last row in use ends, then one result per cycle while out_stall is low,
// over the single result shift chain. Reset is synchronous and active low; it clears control
// state and accumulators and sets the configuration defaults. Depends on mmbr_pkg and mmbr_cell.
`default_nettype none

module matrix_multiply_bias_relu import mmbr_pkg::*; #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_req_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_req_t                   out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam logic [6:0]  MAXR7  = 7'(MAX_ROWS);
  localparam logic [10:0] MAXD11 = 11'(MAX_DEPTH);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  logic [4:0]  rows_used_r;
  logic [6:0]  depth_used_r;
  logic [15:0] cols_used_r;
  logic        add_bias_r;
  logic        relu_enable_r;

  logic [6:0]     rows7;
  logic [RCW-1:0] nrows;
  logic [10:0]    ndep;
  logic [10:0]    in_dep11;
  logic           dep_ok;
  logic           dep_last;
  logic           wgt_ok;
  logic           in_acc;
  logic           is_final;
  logic           out_acc;

  tok_t ent_r;
  tok_t ent_nxt;

  logic [15:0] col_cnt_r;
  logic [15:0] col_out_r;
  logic        last_mat_r;
  logic [15:0] cols_eff;
  logic        last_col;

  logic [RCW-1:0] out_row_r;
  logic           out_last_row;

  tok_t                    chain_tok [MAX_ROWS+1];
  logic signed [RES_W-1:0] chain_res [MAX_ROWS+1];
  logic [MAX_ROWS-1:0]     cap_vec;
  logic [MAX_ROWS-1:0]     row_en;
  logic [MAX_ROWS-1:0]     row_last;
  logic                    cap_last;
  cell_ctrl_t              ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r   <= 5'd16;
      depth_used_r  <= 7'd64;
      cols_used_r   <= 16'd1;
      add_bias_r    <= 1'b0;
      relu_enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROWS_USED:   rows_used_r   <= cfg_data[4:0];
        CFG_DEPTH_USED:  depth_used_r  <= cfg_data[6:0];
        CFG_COLS_USED:   cols_used_r   <= cfg_data;
        CFG_ADD_BIAS:    add_bias_r    <= cfg_data[0];
        CFG_RELU_ENABLE: relu_enable_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rows7 = {2'b00, rows_used_r};
    if (rows7 == 7'd0) begin
      rows7 = 7'd1;
    end else if (rows7 > MAXR7) begin
      rows7 = MAXR7;
    end
    nrows = RCW'(rows7);
    ndep  = {4'b0000, depth_used_r};
    if (ndep == 11'd0) begin
      ndep = 11'd1;
    end else if (ndep > MAXD11) begin
      ndep = MAXD11;
    end
  end

  assign in_dep11 = {5'b00000, in_data.depth_index};
  assign dep_ok   = (in_dep11 < ndep);
  assign dep_last = (in_dep11 == (ndep - 11'd1));
  assign wgt_ok   = (in_dep11 < MAXD11);
  assign in_stall = (state_r != ST_RUN);
  assign in_acc   = in_valid && !in_stall;
  assign is_final = in_acc && (in_data.func == FUNC_STREAM) && dep_ok && dep_last;
  assign out_acc  = out_valid && !out_stall;

  assign cols_eff = (cols_used_r == 16'd0) ? 16'd1 : cols_used_r;
  assign last_col = (({1'b0, col_cnt_r} + 17'd1) >= {1'b0, cols_eff});

  always_comb begin
    ent_nxt.func  = in_data.func;
    ent_nxt.row   = in_data.row_index;
    ent_nxt.dep   = in_data.depth_index;
    ent_nxt.opnd  = in_data.operand;
    ent_nxt.bias  = in_data.bias_value;
    ent_nxt.first = (in_data.depth_index == 6'd0);
    ent_nxt.last  = dep_last;
    ent_nxt.vld   = 1'b0;
    if (in_acc) begin
      priority if (in_data.func == FUNC_WEIGHT) begin
        ent_nxt.vld = wgt_ok;
      end else if (in_data.func == FUNC_BIAS) begin
        ent_nxt.vld = 1'b1;
      end else if (in_data.func == FUNC_STREAM) begin
        ent_nxt.vld = dep_ok;
      end else begin
        ent_nxt.vld = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r.func  <= ent_nxt.func;
    ent_r.row   <= ent_nxt.row;
    ent_r.dep   <= ent_nxt.dep;
    ent_r.opnd  <= ent_nxt.opnd;
    ent_r.bias  <= ent_nxt.bias;
    ent_r.first <= ent_nxt.first;
    ent_r.last  <= ent_nxt.last;
    if (is_final) begin
      col_out_r  <= col_cnt_r;
      last_mat_r <= last_col;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (is_final) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (cap_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_last_row) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      ent_r.vld <= 1'b0;
      col_cnt_r <= '0;
      out_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      ent_r.vld <= ent_nxt.vld;
      if (is_final) begin
        col_cnt_r <= last_col ? 16'd0 : (col_cnt_r + 16'd1);
      end
      if (cap_last) begin
        out_row_r <= '0;
      end else if (out_acc) begin
        out_row_r <= out_row_r + RCW'(1);
      end
    end
  end

  assign ctrl.add_bias    = add_bias_r;
  assign ctrl.relu_enable = relu_enable_r;
  assign ctrl.shift       = out_acc;

  assign chain_tok[0]        = ent_r;
  assign chain_res[MAX_ROWS] = '0;

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    assign row_en[g]   = (RCW'(g) < nrows);
    assign row_last[g] = (RCW'(g) == (nrows - RCW'(1)));

    mmbr_cell #(
      .CELL_IDX  (g),
      .MAX_DEPTH (MAX_DEPTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain_tok[g]),
      .tok_out (chain_tok[g+1]),
      .row_en  (row_en[g]),
      .ctrl    (ctrl),
      .res_in  (chain_res[g+1]),
      .res_out (chain_res[g]),
      .cap     (cap_vec[g])
    );
  end

  assign cap_last     = (state_r == ST_WAIT) && |(cap_vec & row_last);
  assign out_last_row = (out_row_r == (nrows - RCW'(1)));

  assign out_valid               = (state_r == ST_DRAIN);
  assign out_data.result_value   = chain_res[0];
  assign out_data.result_row     = 4'(out_row_r);
  assign out_data.result_col     = col_out_r;
  assign out_data.last_of_column = out_last_row;
  assign out_data.last_of_matrix = out_last_row && last_mat_r;

endmodule

`default_nettype wire

// ===== rtl/mmbr_checker.sv =====
// Port-level checks for the matrix multiply with bias and ReLU block, bound to its top level.
// Depends on mmbr_pkg and matrix_multiply_bias_relu.
`default_nettype none

module mmbr_checker import mmbr_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire out_req_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result request changed or dropped");

  a_in_stalled_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results are pending");

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_column |=> out_valid)
    else $error("column ended before its last row");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_of_column |=> !out_valid)
    else $error("results continued past the last row");

  a_matrix_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_matrix |-> out_data.last_of_column)
    else $error("matrix end flagged on a row that is not the last");

endmodule

bind matrix_multiply_bias_relu mmbr_checker u_mmbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
